FILE: rtl/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the stepper angle positioner.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int SWEEP_LIMIT_DEF = 2500;
    localparam int GRACE_STEPS_DEF = 250;
    localparam int CHECK_GAP_DEF   = 10;

    localparam logic [2:0] CFG_BASE  = 3'd0;
    localparam logic [2:0] CFG_RANGE = 3'd1;
    localparam logic [2:0] CFG_FIXED = 3'd2;
    localparam logic [2:0] CFG_DEFMX = 3'd3;
    localparam logic [2:0] CFG_HASSW = 3'd4;
    localparam logic [2:0] CFG_ENAH  = 3'd5;
    localparam logic [2:0] CFG_DIRLH = 3'd6;
    localparam logic [2:0] CFG_STOPH = 3'd7;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_IDLE = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEFT, PH_RIGHT, PH_CENTER, PH_MOVE
    } phase_t;

    // divider command and status
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_sts_t;

endpackage

FILE: rtl/sap_div.sv
// ----------------------------------------------------------------------------
// sap_div
// Restoring divider, one quotient bit per cycle, 16 bit operands.
// ----------------------------------------------------------------------------
module sap_div
    import sap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_sts_t sts
);

    logic [15:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [16:0] trial;

    assign trial = {r_reg[15:0], q_reg[15]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                q_reg   <= cmd.dividend;
                d_reg   <= cmd.divisor;
                r_reg   <= '0;
                cnt_reg <= 5'd16;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (!trial[16])
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[14:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[15:0], q_reg[15]};
                    q_reg <= {q_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.done     = done_reg;
    assign sts.quotient = q_reg;

endmodule

FILE: rtl/sap_ctrl.sv
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer and state of the positioner; uses the shared divider.
// ----------------------------------------------------------------------------
module sap_ctrl
    import sap_pkg::*;
#(
    parameter int SWEEP_LIMIT = SWEEP_LIMIT_DEF,
    parameter int GRACE_STEPS = GRACE_STEPS_DEF,
    parameter int CHECK_GAP   = CHECK_GAP_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic        limit_level,
    input  logic [8:0]  target_angle,
    input  logic signed [7:0] speed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        step_level,
    output logic        dir_level,
    output logic        enable_level,
    output logic        busy_res,
    output logic [11:0] steps_done,
    output logic        limit_stop,
    output logic [8:0]  position_angle,
    output div_cmd_t    dcmd,
    input  div_sts_t    dsts
);

    localparam logic [11:0] SWEEP_N  = 12'(SWEEP_LIMIT);
    localparam logic [11:0] SWEEP_OK = 12'(SWEEP_LIMIT - 10);
    localparam logic [7:0]  GRACE_N  = 8'(GRACE_STEPS);
    localparam logic [3:0]  GAP_N    = 4'(CHECK_GAP);

    typedef enum logic [2:0] {
        S_READY, S_DIVHP, S_DIVPER, S_MUL, S_CHAIN, S_OUT
    } st_t;

    // config
    logic [15:0] base_reg;
    logic [8:0]  range_reg;
    logic [11:0] fixed_reg, defmx_reg;
    logic        hassw_reg, enah_reg, dirlh_reg, stoph_reg;

    // model state
    st_t         st_reg;
    phase_t      ph_reg;
    logic [8:0]  cur_reg, pend_reg;
    logic [11:0] span_reg, left_reg, cnt_reg;
    logic [15:0] ht_reg, hp_reg;
    logic [7:0]  grace_reg;
    logic [3:0]  chk_reg;
    logic        gon_reg, pstep_reg, pdir_reg, drv_reg, stop_reg, lvl_reg;
    logic        stopk_reg, mvgo_reg;
    logic [20:0] prod_reg;
    logic [15:0] dend_reg, dsor_reg;
    logic        dgo_reg;

    logic        reached_w;
    assign reached_w = hassw_reg && (lvl_reg == stoph_reg);

    logic signed [7:0] sclamp;
    logic [9:0]  hi_a, lo_a;
    logic [8:0]  aclamp;
    logic [8:0]  rng1;
    logic [8:0]  adiff;
    logic [11:0] span_sel;

    always_comb
    begin
        sclamp = speed;
        if (speed < 8'sd1)
            sclamp = 8'sd1;
        else if (speed > 8'sd10)
            sclamp = 8'sd10;
        hi_a = 10'd90 + 10'(range_reg[8:1]);
        lo_a = 10'd90 - 10'(range_reg[8:1]);
        aclamp = target_angle;
        if ({1'b0, target_angle} > hi_a)
            aclamp = hi_a[8:0];
        else if (lo_a[9] == 1'b0 && {1'b0, target_angle} < lo_a)
            aclamp = lo_a[8:0];
        rng1 = (range_reg == '0) ? 9'd1 : range_reg;
        adiff = (pend_reg < cur_reg) ? cur_reg - pend_reg : pend_reg - cur_reg;
        span_sel = (fixed_reg != '0) ? fixed_reg : defmx_reg;
    end

    assign in_stall  = (st_reg != S_READY) || out_valid;
    assign dcmd.start    = dgo_reg;
    assign dcmd.dividend = dend_reg;
    assign dcmd.divisor  = dsor_reg;

    assign step_level     = pstep_reg;
    assign dir_level      = pdir_reg;
    assign enable_level   = drv_reg ? enah_reg : ~enah_reg;
    assign busy_res       = ph_reg != PH_IDLE;
    assign steps_done     = cnt_reg;
    assign limit_stop     = stop_reg;
    assign position_angle = cur_reg;

    logic ovalid_reg;
    assign out_valid = ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 16'd400; range_reg <= 9'd180; fixed_reg <= '0;
            defmx_reg <= 12'd900; hassw_reg <= 1'b0; enah_reg <= 1'b0;
            dirlh_reg <= 1'b0; stoph_reg <= 1'b0;
            st_reg <= S_READY; ph_reg <= PH_IDLE;
            cur_reg <= '0; pend_reg <= '0; span_reg <= '0; left_reg <= '0;
            cnt_reg <= '0; ht_reg <= '0; hp_reg <= '0; grace_reg <= '0;
            chk_reg <= '0; gon_reg <= 1'b0; pstep_reg <= 1'b0; pdir_reg <= 1'b0;
            drv_reg <= 1'b0; stop_reg <= 1'b0; lvl_reg <= 1'b0;
            stopk_reg <= 1'b0; mvgo_reg <= 1'b0;
            ovalid_reg <= 1'b0; dgo_reg <= 1'b0;
            prod_reg <= '0; dend_reg <= '0; dsor_reg <= '0;
        end
        else
        begin
            dgo_reg <= 1'b0;
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE:  base_reg  <= cfg_data;
                    CFG_RANGE: range_reg <= cfg_data[8:0];
                    CFG_FIXED: fixed_reg <= cfg_data[11:0];
                    CFG_DEFMX: defmx_reg <= cfg_data[11:0];
                    CFG_HASSW: hassw_reg <= cfg_data[0];
                    CFG_ENAH:  enah_reg  <= cfg_data[0];
                    CFG_DIRLH: dirlh_reg <= cfg_data[0];
                    CFG_STOPH: stoph_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            unique case (st_reg)
                S_READY:
                begin
                    if (in_valid && !in_stall)
                    begin
                        lvl_reg <= limit_level;
                        st_reg  <= S_OUT;
                        if (cmd == CMD_TICK)
                        begin
                            if (ph_reg != PH_IDLE)
                            begin
                                if (ht_reg > 16'd1)
                                    ht_reg <= ht_reg - 16'd1;
                                else if (pstep_reg)
                                begin
                                    pstep_reg <= 1'b0;
                                    ht_reg <= hp_reg;
                                end
                                else
                                    st_reg <= S_MUL; // step completion handled below
                            end
                        end
                        else if (cmd == CMD_MOVE)
                        begin
                            if (ph_reg == PH_IDLE)
                            begin
                                pend_reg <= aclamp;
                                dend_reg <= base_reg;
                                dsor_reg <= 16'(unsigned'(sclamp));
                                dgo_reg  <= 1'b1;
                                st_reg   <= S_DIVHP;
                            end
                        end
                        else if (cmd == CMD_IDLE)
                        begin
                            ph_reg <= PH_IDLE;
                            pstep_reg <= 1'b0;
                            drv_reg <= 1'b0;
                        end
                    end
                end
                S_MUL:
                begin
                    // step completion on tick
                    logic stop_w;
                    stop_w = 1'b0;
                    if (gon_reg && grace_reg > 8'd0)
                        grace_reg <= grace_reg - 8'd1;
                    else if (chk_reg == 4'd0)
                    begin
                        if (hassw_reg)
                        begin
                            chk_reg <= GAP_N;
                            stop_w = reached_w;
                        end
                    end
                    else
                        chk_reg <= chk_reg - 4'd1;
                    if (stop_w)
                    begin
                        // flag survives the run changes, shown with the result
                        stopk_reg <= 1'b1;
                        st_reg <= S_CHAIN;
                    end
                    else
                    begin
                        if (cnt_reg != 12'hFFF)
                            cnt_reg <= cnt_reg + 12'd1;
                        if (left_reg <= 12'd1)
                        begin
                            left_reg <= '0;
                            st_reg <= S_CHAIN;
                        end
                        else
                        begin
                            left_reg <= left_reg - 12'd1;
                            pstep_reg <= 1'b1;
                            ht_reg <= hp_reg;
                            st_reg <= S_OUT;
                        end
                    end
                end
                S_DIVHP:
                begin
                    if (dsts.done)
                    begin
                        hp_reg <= (dsts.quotient == '0) ? 16'd1 : dsts.quotient;
                        drv_reg <= 1'b1;
                        if (!hassw_reg)
                            span_reg <= span_sel;
                        if ((!hassw_reg && span_sel == '0)
                            || (hassw_reg && span_reg == '0))
                        begin
                            pdir_reg <= 1'b1;
                            ph_reg <= PH_LEFT;
                            cnt_reg <= '0; left_reg <= SWEEP_N;
                            grace_reg <= GRACE_N; chk_reg <= GAP_N;
                            gon_reg <= reached_w; stop_reg <= 1'b0;
                            if (SWEEP_N != '0)
                            begin
                                pstep_reg <= 1'b1;
                                ht_reg <= (dsts.quotient == '0) ? 16'd1 : dsts.quotient;
                                st_reg <= S_OUT;
                            end
                            else
                                st_reg <= S_CHAIN;
                        end
                        else
                        begin
                            ph_reg <= PH_MOVE;
                            dend_reg <= 16'(hassw_reg ? span_reg : span_sel);
                            dsor_reg <= 16'(rng1);
                            dgo_reg <= 1'b1;
                            st_reg <= S_DIVPER;
                        end
                    end
                end
                S_DIVPER:
                begin
                    if (dsts.done)
                    begin
                        if (pend_reg < cur_reg)
                            pdir_reg <= ~dirlh_reg;
                        else if (pend_reg != cur_reg)
                            pdir_reg <= dirlh_reg;
                        prod_reg <= 21'(adiff) * 21'(dsts.quotient[11:0]);
                        st_reg <= S_CHAIN;
                        ph_reg <= PH_MOVE;
                        mvgo_reg <= 1'b1;
                        cnt_reg <= '0; grace_reg <= GRACE_N; chk_reg <= GAP_N;
                        gon_reg <= reached_w; stop_reg <= 1'b0;
                    end
                end
                S_CHAIN:
                begin
                    st_reg <= S_OUT;
                    if (mvgo_reg)
                    begin
                        // move length, saturated
                        logic [11:0] n;
                        n = (prod_reg[20:12] != '0) ? 12'hFFF : prod_reg[11:0];
                        mvgo_reg <= 1'b0;
                        left_reg <= n;
                        if (n != '0)
                        begin
                            pstep_reg <= 1'b1;
                            ht_reg <= hp_reg;
                        end
                        else
                        begin
                            cur_reg <= pend_reg; drv_reg <= 1'b0;
                            pstep_reg <= 1'b0; ph_reg <= PH_IDLE;
                        end
                    end
                    else
                    begin
                        unique case (ph_reg)
                            PH_LEFT:
                            begin
                                cnt_reg <= '0; grace_reg <= GRACE_N; chk_reg <= GAP_N;
                                gon_reg <= reached_w; stop_reg <= 1'b0;
                                pdir_reg <= 1'b0; ph_reg <= PH_RIGHT;
                                left_reg <= SWEEP_N;
                                pstep_reg <= 1'b1; ht_reg <= hp_reg;
                            end
                            PH_RIGHT:
                            begin
                                logic [11:0] sp;
                                sp = (cnt_reg >= SWEEP_OK) ? defmx_reg : cnt_reg;
                                cnt_reg <= '0; grace_reg <= GRACE_N; chk_reg <= GAP_N;
                                gon_reg <= reached_w; stop_reg <= 1'b0;
                                span_reg <= sp; pdir_reg <= 1'b1;
                                ph_reg <= PH_CENTER;
                                left_reg <= {1'b0, sp[11:1]};
                                if (sp[11:1] != '0)
                                begin
                                    pstep_reg <= 1'b1; ht_reg <= hp_reg;
                                end
                                else
                                    st_reg <= S_CHAIN;
                            end
                            PH_CENTER:
                            begin
                                cur_reg <= 9'd90;
                                dend_reg <= 16'(span_reg);
                                dsor_reg <= 16'(rng1);
                                dgo_reg <= 1'b1;
                                st_reg <= S_DIVPER;
                            end
                            default:
                            begin
                                cur_reg <= pend_reg; drv_reg <= 1'b0;
                                pstep_reg <= 1'b0; ph_reg <= PH_IDLE;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (stopk_reg)
                        stop_reg <= 1'b1;
                    stopk_reg <= 1'b0;
                    ovalid_reg <= 1'b1;
                    st_reg <= S_READY;
                end
                default: st_reg <= S_READY;
            endcase
        end
    end

endmodule

FILE: rtl/stepper_angle_positioner.sv
// ----------------------------------------------------------------------------
// stepper_angle_positioner
// Step/dir/enable generator with homing sweep and limit switch checks.
// ----------------------------------------------------------------------------
// Path to the result: a tick passes S_READY and S_OUT; a completed step adds
// S_MUL, and S_CHAIN at a run end or limit stop. The divider runs once for
// a sweep end into centring or a move starting a sweep, twice for others.
// Throughput: one word at a time; next word taken after the result is taken.
// Reset: asynchronous, registers to defaults, driver disabled, not calibrated.
module stepper_angle_positioner
    import sap_pkg::*;
#(
    parameter int SWEEP_LIMIT = SWEEP_LIMIT_DEF,
    parameter int GRACE_STEPS = GRACE_STEPS_DEF,
    parameter int CHECK_GAP   = CHECK_GAP_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic        limit_level,
    input  logic [8:0]  target_angle,
    input  logic signed [7:0] speed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        step_level,
    output logic        dir_level,
    output logic        enable_level,
    output logic        busy_res,
    output logic [11:0] steps_done,
    output logic        limit_stop,
    output logic [8:0]  position_angle
);

    div_cmd_t dcmd;
    div_sts_t dsts;

    sap_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts));

    sap_ctrl #(
        .SWEEP_LIMIT(SWEEP_LIMIT), .GRACE_STEPS(GRACE_STEPS), .CHECK_GAP(CHECK_GAP)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .limit_level(limit_level), .target_angle(target_angle), .speed(speed),
        .out_valid(out_valid), .out_stall(out_stall), .step_level(step_level),
        .dir_level(dir_level), .enable_level(enable_level), .busy_res(busy_res),
        .steps_done(steps_done), .limit_stop(limit_stop),
        .position_angle(position_angle), .dcmd(dcmd), .dsts(dsts)
    );

endmodule

FILE: rtl/sap_checker.sv
// ----------------------------------------------------------------------------
// sap_checker
// Port level checks of the positioner.
// ----------------------------------------------------------------------------
module sap_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       busy_res,
    input logic       step_level,
    input logic [8:0] position_angle
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("word taken while result pending");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !step_level) else $error("step while idle");
    a_ang: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position_angle < 9'd360) else $error("angle out of range");

endmodule

bind stepper_angle_positioner sap_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .busy_res(busy_res),
    .step_level(step_level), .position_angle(position_angle)
);
